// ===== rtl/pps_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, latencies, constants and types of the phong pixel shader
package pps_pkg;

  // field widths
  localparam int COL_W      = 8;
  localparam int PT_W       = 16;
  localparam int LIGHT_W    = 64;
  localparam int INTEN_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LIGHT_REGS = 4;

  // raw direction before normalizing, and normalized Q1.14 direction
  localparam int RAW_W = 19;
  localparam int DIR_W = 16;

  // normalizer: three setup stages, one stage per quotient bit and per root bit, one output
  localparam int DIV_STEPS  = 29;
  localparam int SQRT_STEPS = 15;
  localparam int NORM_LAT   = 3 + DIV_STEPS + SQRT_STEPS + 1;

  localparam int REFL_LAT = 3;
  localparam int POW_LAT  = 9;
  // light lane: L normalize, reflection, R normalize, R.V, power, terms
  localparam int LANE_LAT = 2 * NORM_LAT + REFL_LAT + 2 + POW_LAT + 3;

  localparam int LN_W   = 17;
  localparam int RV_W   = 15;
  localparam int TERM_W = 29;

  localparam int ONE_Q14 = 16384;
  localparam int DIFF_K  = 19661;
  localparam int SPEC_K  = 655;

  localparam logic signed [PT_W-1:0] CAM_Z_RESET = -16'sd1000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_3     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z    = 3'd5;

  typedef logic signed [PT_W-1:0]  coord_t;
  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [DIR_W-1:0] dir_t;

endpackage

// ===== rtl/pps_in_if.sv =====
`timescale 1ns / 1ps
// fragment input channel: texel color, surface point and normal
interface pps_in_if;
  logic                  valid;
  logic                  ready;
  logic [7:0]            color_red;
  logic [7:0]            color_green;
  logic [7:0]            color_blue;
  logic signed [15:0]    point_x;
  logic signed [15:0]    point_y;
  logic signed [15:0]    point_z;
  logic signed [15:0]    normal_x;
  logic signed [15:0]    normal_y;
  logic signed [15:0]    normal_z;

  modport source (
    output valid, color_red, color_green, color_blue,
    output point_x, point_y, point_z, normal_x, normal_y, normal_z,
    input  ready
  );
  modport sink (
    input  valid, color_red, color_green, color_blue,
    input  point_x, point_y, point_z, normal_x, normal_y, normal_z,
    output ready
  );
endinterface

// ===== rtl/pps_out_if.sv =====
`timescale 1ns / 1ps
// shaded pixel output channel
interface pps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] shaded_red;
  logic [7:0] shaded_green;
  logic [7:0] shaded_blue;

  modport source (output valid, shaded_red, shaded_green, shaded_blue, input ready);
  modport sink (input valid, shaded_red, shaded_green, shaded_blue, output ready);
endinterface

// ===== rtl/pps_delay.sv =====
`timescale 1ns / 1ps
// enabled shift register that delays a payload word by a fixed number of stages
module pps_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] dly_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= d;
      for (int k = 1; k < D; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  assign q = dly_r[D-1];

endmodule

// ===== rtl/pps_norm.sv =====
`timescale 1ns / 1ps
// pipelined vector normalizer: squares, bit-per-stage divide, bit-pair-per-stage root
module pps_norm (
  input  logic            clk,
  input  logic            en,
  input  pps_pkg::raw_t   vec_i [3],
  output pps_pkg::dir_t   vec_o [3]
);

  localparam int MW  = pps_pkg::RAW_W;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int RW  = SW + 1;
  localparam int DN  = pps_pkg::DIV_STEPS;
  localparam int QW  = DN;
  localparam int XN  = pps_pkg::SQRT_STEPS;
  localparam int XW  = 2 * XN;

  logic           neg0_r [3];
  logic [MW-1:0]  mag0_r [3];
  logic           neg1_r [3];
  logic [SQW-1:0] sq1_r  [3];
  logic           neg2_r [3];
  logic [SQW-1:0] sq2_r  [3];
  logic [SW-1:0]  s2_r;

  logic [RW-1:0]  rem_r  [DN][3];
  logic [QW-1:0]  q_r    [DN][3];
  logic           dneg_r [DN][3];
  logic [SW-1:0]  ds_r   [DN];
  logic           dzero_r [DN];
  logic [RW-1:0]  dsh    [1:DN-1][3];
  logic           dbit   [1:DN-1][3];

  logic [XW-1:0]  x_r    [XN][3];
  logic [XW-1:0]  r_r    [XN][3];
  logic           xneg_r [XN][3];
  logic           xzero_r [XN];
  logic [XW-1:0]  sx_in  [XN][3];
  logic [XW-1:0]  sr_in  [XN][3];
  logic [XW-1:0]  ssum   [XN][3];
  logic [XW-1:0]  sx_nxt [XN][3];
  logic [XW-1:0]  sr_nxt [XN][3];

  pps_pkg::dir_t  vec_r  [3];

  // restoring divide: one quotient bit per stage
  for (genvar j = 1; j < DN; j++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_c
      assign dsh[j][i]  = {rem_r[j-1][i][RW-2:0], 1'b0};
      assign dbit[j][i] = dsh[j][i] >= RW'(ds_r[j-1]);
    end
  end

  // integer root: one result bit per stage
  for (genvar j = 0; j < XN; j++) begin : g_sq
    localparam logic [XW-1:0] STEP_BIT = XW'(1) << (2 * (XN - 1 - j));
    for (genvar i = 0; i < 3; i++) begin : g_c
      if (j == 0) begin : g_first
        assign sx_in[j][i] = XW'(q_r[DN-1][i]);
        assign sr_in[j][i] = '0;
      end else begin : g_next
        assign sx_in[j][i] = x_r[j-1][i];
        assign sr_in[j][i] = r_r[j-1][i];
      end
      assign ssum[j][i]   = sr_in[j][i] + STEP_BIT;
      assign sx_nxt[j][i] = (sx_in[j][i] >= ssum[j][i]) ? sx_in[j][i] - ssum[j][i]
                                                         : sx_in[j][i];
      assign sr_nxt[j][i] = (sx_in[j][i] >= ssum[j][i]) ? (sr_in[j][i] >> 1) + STEP_BIT
                                                         : sr_in[j][i] >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg0_r[i] <= vec_i[i][MW-1];
        mag0_r[i] <= vec_i[i][MW-1] ? MW'(-vec_i[i]) : MW'(vec_i[i]);
        neg1_r[i] <= neg0_r[i];
        sq1_r[i]  <= SQW'(mag0_r[i]) * SQW'(mag0_r[i]);
        neg2_r[i] <= neg1_r[i];
        sq2_r[i]  <= sq1_r[i];
      end
      s2_r <= SW'(sq1_r[0]) + SW'(sq1_r[1]) + SW'(sq1_r[2]);

      // each square is at most the sum, so the top quotient bit is set only on equality
      ds_r[0]    <= s2_r;
      dzero_r[0] <= (s2_r == '0);
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i]  <= (SW'(sq2_r[i]) >= s2_r) ? RW'(SW'(sq2_r[i]) - s2_r)
                                                 : RW'(sq2_r[i]);
        q_r[0][i]    <= QW'(SW'(sq2_r[i]) >= s2_r);
        dneg_r[0][i] <= neg2_r[i];
      end
      for (int j = 1; j < DN; j++) begin
        ds_r[j]    <= ds_r[j-1];
        dzero_r[j] <= dzero_r[j-1];
        for (int i = 0; i < 3; i++) begin
          rem_r[j][i]  <= dbit[j][i] ? dsh[j][i] - RW'(ds_r[j-1]) : dsh[j][i];
          q_r[j][i]    <= {q_r[j-1][i][QW-2:0], dbit[j][i]};
          dneg_r[j][i] <= dneg_r[j-1][i];
        end
      end

      xzero_r[0] <= dzero_r[DN-1];
      for (int i = 0; i < 3; i++) begin
        xneg_r[0][i] <= dneg_r[DN-1][i];
      end
      for (int j = 1; j < XN; j++) begin
        xzero_r[j] <= xzero_r[j-1];
        for (int i = 0; i < 3; i++) begin
          xneg_r[j][i] <= xneg_r[j-1][i];
        end
      end
      for (int j = 0; j < XN; j++) begin
        for (int i = 0; i < 3; i++) begin
          x_r[j][i] <= sx_nxt[j][i];
          r_r[j][i] <= sr_nxt[j][i];
        end
      end

      // zero-length vector stays zero
      for (int i = 0; i < 3; i++) begin
        if (xzero_r[XN-1]) begin
          vec_r[i] <= '0;
        end else if (xneg_r[XN-1][i]) begin
          vec_r[i] <= -pps_pkg::DIR_W'(r_r[XN-1][i]);
        end else begin
          vec_r[i] <= pps_pkg::DIR_W'(r_r[XN-1][i]);
        end
      end
    end
  end

  assign vec_o = vec_r;

endmodule

// ===== rtl/pps_pow.sv =====
`timescale 1ns / 1ps
// pipelined Q14 power of 200 by repeated squaring, one multiply per stage
module pps_pow (
  input  logic                        clk,
  input  logic                        en,
  input  logic [pps_pkg::RV_W-1:0]    x,
  output logic [pps_pkg::RV_W-1:0]    y
);

  localparam int VW = pps_pkg::RV_W;
  localparam int PW = 2 * VW;

  function automatic logic [VW-1:0] qmul(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return p[VW+13:14];
  endfunction

  logic [VW-1:0] a2_r, a4_r, p8_r, a16_r, a32_r, p64_r, p128_r, t_r, y_r;
  logic [VW-1:0] c8_r [4:8];
  logic [VW-1:0] c64_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r   <= qmul(x, x);
      a4_r   <= qmul(a2_r, a2_r);
      p8_r   <= qmul(a4_r, a4_r);
      a16_r  <= qmul(p8_r, p8_r);
      c8_r[4] <= p8_r;
      a32_r  <= qmul(a16_r, a16_r);
      c8_r[5] <= c8_r[4];
      p64_r  <= qmul(a32_r, a32_r);
      c8_r[6] <= c8_r[5];
      p128_r <= qmul(p64_r, p64_r);
      c64_r  <= p64_r;
      c8_r[7] <= c8_r[6];
      t_r    <= qmul(p128_r, c64_r);
      c8_r[8] <= c8_r[7];
      y_r    <= qmul(t_r, c8_r[8]);
    end
  end

  assign y = y_r;

endmodule

// ===== rtl/pps_lane.sv =====
`timescale 1ns / 1ps
// one light lane: light direction, reflection, specular power and weighted terms
module pps_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pps_pkg::LIGHT_W-1:0]  light_word,
  input  pps_pkg::coord_t              pt [3],
  input  pps_pkg::coord_t              nrm [3],
  input  pps_pkg::dir_t                view [3],
  output logic [pps_pkg::TERM_W-1:0]   term
);

  localparam int LN_W   = pps_pkg::LN_W;
  localparam int RV_W   = pps_pkg::RV_W;
  localparam int IW     = pps_pkg::INTEN_W;
  localparam int LN_DLY = pps_pkg::NORM_LAT + 2 + pps_pkg::POW_LAT;

  pps_pkg::raw_t   lraw [3];
  pps_pkg::dir_t   ldir [3];
  pps_pkg::dir_t   rdir [3];
  logic [IW-1:0]   inten;

  logic signed [31:0] p_r  [3];
  pps_pkg::coord_t    n1_r [3];
  pps_pkg::dir_t      l1_r [3];
  pps_pkg::dir_t      l2_r [3];
  logic signed [47:0] q_r  [3];
  logic signed [33:0] dot_r;
  logic signed [48:0] q2   [3];
  logic [48:0]        qm   [3];
  logic signed [21:0] tq   [3];
  pps_pkg::raw_t      rraw_r [3];
  logic [LN_W-1:0]    ln_r;
  logic [LN_W-1:0]    ln_d;

  logic signed [31:0] rvp_r [3];
  logic signed [33:0] rv_sum;
  logic [RV_W-1:0]    rv_r;
  logic [RV_W-1:0]    sp;

  logic [32:0]        a_r;
  logic [30:0]        b_r;
  logic [47:0]        a_k;
  logic [40:0]        b_k;
  logic [27:0]        diff_r;
  logic [18:0]        spec_r;
  logic [pps_pkg::TERM_W-1:0] term_r;

  assign inten = light_word[63:48];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lraw[i] = pps_pkg::RAW_W'($signed(light_word[16*i +: 16])) - pps_pkg::RAW_W'(pt[i]);
    end
  end

  pps_norm u_lnorm (
    .clk   (clk),
    .en    (en),
    .vec_i (lraw),
    .vec_o (ldir)
  );

  // reflection uses the component-wise product, truncated toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q2[i] = $signed({q_r[i], 1'b0});
      qm[i] = q2[i][48] ? 49'(-q2[i]) : 49'(q2[i]);
      tq[i] = q2[i][48] ? -$signed({1'b0, qm[i][48:28]}) : $signed({1'b0, qm[i][48:28]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i]    <= 32'(ldir[i]) * 32'(nrm[i]);
        n1_r[i]   <= nrm[i];
        l1_r[i]   <= ldir[i];
        q_r[i]    <= 48'(p_r[i]) * 48'(n1_r[i]);
        l2_r[i]   <= l1_r[i];
        rraw_r[i] <= pps_pkg::RAW_W'(23'(tq[i]) - 23'(l2_r[i]));
      end
      dot_r <= 34'(p_r[0]) + 34'(p_r[1]) + 34'(p_r[2]);
      ln_r  <= (dot_r > 34'sd0) ? LN_W'(dot_r[33:14]) : '0;
    end
  end

  pps_norm u_rnorm (
    .clk   (clk),
    .en    (en),
    .vec_i (rraw_r),
    .vec_o (rdir)
  );

  assign rv_sum = 34'(rvp_r[0]) + 34'(rvp_r[1]) + 34'(rvp_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rvp_r[i] <= 32'(rdir[i]) * 32'(view[i]);
      end
      if (rv_sum <= 34'sd0) begin
        rv_r <= '0;
      end else if (rv_sum[33:14] > 20'(pps_pkg::ONE_Q14)) begin
        rv_r <= RV_W'(pps_pkg::ONE_Q14);
      end else begin
        rv_r <= RV_W'(rv_sum[33:14]);
      end
    end
  end

  pps_pow u_pow (
    .clk (clk),
    .en  (en),
    .x   (rv_r),
    .y   (sp)
  );

  pps_delay #(.W(LN_W), .D(LN_DLY)) u_ln_dly (
    .clk (clk),
    .en  (en),
    .d   (ln_r),
    .q   (ln_d)
  );

  assign a_k = 48'(a_r) * 48'(pps_pkg::DIFF_K);
  assign b_k = 41'(b_r) * 41'(pps_pkg::SPEC_K);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= 33'(ln_d) * 33'(inten);
      b_r    <= 31'(sp) * 31'(inten);
      diff_r <= a_k[47:20];
      spec_r <= b_k[40:22];
      term_r <= pps_pkg::TERM_W'(diff_r) + pps_pkg::TERM_W'(spec_r);
    end
  end

  assign term = term_r;

endmodule

// ===== rtl/phong_pixel_shader_top.sv =====
`timescale 1ns / 1ps
// phong pixel shader top level: config registers, view direction, light lanes, color scale
//
// Fragments enter on in_ch (valid/ready) with a texel color, a surface point and a normal;
// each produces one shaded pixel on out_ch. A transaction completes when valid and ready
// are both high. Lights and the camera depth are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no fragment is in flight, which the block does not
// enforce. Indexes outside the register list are ignored. Each fragment passes through two
// normalizers in series (48 stages each, one divide bit or root bit per stage), the
// reflection, the power chain and the weighting multiplies. One fragment is accepted every
// cycle while out_ch is not stalled; all lights are processed in parallel lanes.
// When out_ch holds a pixel that is not taken, the whole pipeline holds and in_ch.ready
// drops; nothing is lost or repeated. Synchronous reset empties the pipeline and sets no
// lights and a camera depth of -1000.
module phong_pixel_shader_top #(
  parameter int MAX_LIGHTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0]    cfg_data,
  pps_in_if.sink                            in_ch,
  pps_out_if.source                         out_ch
);

  localparam int LANES = (MAX_LIGHTS < pps_pkg::LIGHT_REGS) ? MAX_LIGHTS : pps_pkg::LIGHT_REGS;
  localparam int VLAT  = pps_pkg::LANE_LAT + 1;
  localparam int IP_W  = pps_pkg::TERM_W + $clog2(LANES + 1);
  localparam int CW    = pps_pkg::COL_W;
  localparam int PRW   = CW + IP_W;

  logic [2:0]                    count_r;
  logic [pps_pkg::LIGHT_W-1:0]   light_r [LANES];
  pps_pkg::coord_t               cam_z_r;

  logic                          en;
  logic                          p0_valid_r;
  logic [CW-1:0]                 col_r [3];
  pps_pkg::coord_t               pt_r  [3];
  pps_pkg::coord_t               nrm_r [3];
  logic                          vpipe_r [VLAT];

  pps_pkg::raw_t                 vraw [3];
  pps_pkg::dir_t                 vdir [3];
  pps_pkg::dir_t                 vdir_d [3];
  pps_pkg::coord_t               nrm_d [3];
  logic [3*CW-1:0]               col_pk_d;
  logic [47:0]                   vdir_pk_d;
  logic [47:0]                   nrm_pk_d;

  logic [pps_pkg::TERM_W-1:0]    term [LANES];
  logic [IP_W-1:0]               ip_sum;
  logic [IP_W-1:0]               ip_r;
  logic [PRW-1:0]                prod [3];
  logic [CW-1:0]                 shade [3];
  logic                          out_valid_r;
  logic [CW-1:0]                 shaded_r [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int k = 0; k < LANES; k++) begin
        light_r[k] <= '0;
      end
      cam_z_r <= pps_pkg::CAM_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        pps_pkg::CFG_LIGHT_COUNT: begin
          count_r <= cfg_data[2:0];
        end
        [pps_pkg::CFG_LIGHT_0:pps_pkg::CFG_LIGHT_3]: begin
          for (int k = 0; k < LANES; k++) begin
            if (cfg_index == pps_pkg::CFG_IDX_W'(pps_pkg::CFG_LIGHT_0 + k)) begin
              light_r[k] <= cfg_data;
            end
          end
        end
        pps_pkg::CFG_CAMERA_Z: begin
          cam_z_r <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  // global advance: the pipeline moves unless a finished pixel is stuck at the output
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
      for (int k = 0; k < VLAT; k++) begin
        vpipe_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      p0_valid_r <= in_ch.valid;
      vpipe_r[0] <= p0_valid_r;
      for (int k = 1; k < VLAT; k++) begin
        vpipe_r[k] <= vpipe_r[k-1];
      end
      out_valid_r <= vpipe_r[VLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r[0] <= in_ch.color_red;
      col_r[1] <= in_ch.color_green;
      col_r[2] <= in_ch.color_blue;
      pt_r[0]  <= in_ch.point_x;
      pt_r[1]  <= in_ch.point_y;
      pt_r[2]  <= in_ch.point_z;
      nrm_r[0] <= in_ch.normal_x;
      nrm_r[1] <= in_ch.normal_y;
      nrm_r[2] <= in_ch.normal_z;
    end
  end

  // view direction toward the camera on the z axis
  assign vraw[0] = -pps_pkg::RAW_W'(pt_r[0]);
  assign vraw[1] = -pps_pkg::RAW_W'(pt_r[1]);
  assign vraw[2] = pps_pkg::RAW_W'(cam_z_r) - pps_pkg::RAW_W'(pt_r[2]);

  pps_norm u_vnorm (
    .clk   (clk),
    .en    (en),
    .vec_i (vraw),
    .vec_o (vdir)
  );

  pps_delay #(.W(48), .D(pps_pkg::NORM_LAT + pps_pkg::REFL_LAT)) u_view_dly (
    .clk (clk),
    .en  (en),
    .d   ({vdir[2], vdir[1], vdir[0]}),
    .q   (vdir_pk_d)
  );

  pps_delay #(.W(48), .D(pps_pkg::NORM_LAT)) u_nrm_dly (
    .clk (clk),
    .en  (en),
    .d   ({nrm_r[2], nrm_r[1], nrm_r[0]}),
    .q   (nrm_pk_d)
  );

  pps_delay #(.W(3 * CW), .D(VLAT)) u_col_dly (
    .clk (clk),
    .en  (en),
    .d   ({col_r[2], col_r[1], col_r[0]}),
    .q   (col_pk_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vdir_d[i] = vdir_pk_d[16*i +: 16];
      nrm_d[i]  = nrm_pk_d[16*i +: 16];
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    pps_lane u_lane (
      .clk        (clk),
      .en         (en),
      .light_word (light_r[k]),
      .pt         (pt_r),
      .nrm        (nrm_d),
      .view       (vdir_d),
      .term       (term[k])
    );
  end

  // sum over the active lights; zero active lights gives black
  always_comb begin
    ip_sum = '0;
    for (int k = 0; k < LANES; k++) begin
      if (32'(count_r) > k) begin
        ip_sum = ip_sum + IP_W'(term[k]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]  = PRW'(col_pk_d[CW*c +: CW]) * PRW'(ip_r);
      shade[c] = (prod[c][PRW-1:16] > (PRW-16)'(255)) ? CW'(255) : prod[c][CW+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip_r <= ip_sum;
      for (int c = 0; c < 3; c++) begin
        shaded_r[c] <= shade[c];
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.shaded_red   = shaded_r[0];
  assign out_ch.shaded_green = shaded_r[1];
  assign out_ch.shaded_blue  = shaded_r[2];

  // a held pipeline keeps its occupancy at both ends
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(p0_valid_r) && $stable(vpipe_r[VLAT-1]) && $stable(out_valid_r))
    else $error("pipeline valid moved during a stall");

  // a zero lighting sum must give a black pixel
  a_zero_sum_black: assert property (@(posedge clk) disable iff (!rst_n)
    en && ip_r == '0 |=> shaded_r[0] == '0 && shaded_r[1] == '0 && shaded_r[2] == '0)
    else $error("nonzero pixel from zero lighting sum");

  // reset empties the pipeline ends
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !p0_valid_r && !vpipe_r[VLAT-1])
    else $error("pipeline not empty after reset");

endmodule

// ===== verif/phong_pixel_shader_top_tb.sv =====
`timescale 1ns / 1ps
// testbench of the phong pixel shader: random fragments and light setups against a predictor
module phong_pixel_shader_top_tb;

  localparam int NUM_LIGHTS = 4;
  localparam int LATENCY    = 115;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct {
    logic [7:0]         col [3];
    logic signed [15:0] pt [3];
    logic signed [15:0] nrm [3];
  } fragment_t;

  class shade_scoreboard;
    pixel_t      pending[$];
    logic [2:0]  light_count;
    logic [63:0] light_word [NUM_LIGHTS];
    logic signed [15:0] camera_z;
    int errors;

    function void clear();
      light_count = '0;
      foreach (light_word[i]) light_word[i] = '0;
      camera_z = pps_pkg::CAM_Z_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      if (idx == pps_pkg::CFG_LIGHT_COUNT) light_count = data[2:0];
      else if (idx >= pps_pkg::CFG_LIGHT_0 && idx <= pps_pkg::CFG_LIGHT_3)
        light_word[idx - pps_pkg::CFG_LIGHT_0] = data;
      else if (idx == pps_pkg::CFG_CAMERA_Z) camera_z = data[15:0];
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void unit_vec(input longint c [3], output longint o [3]);
      longint unsigned s, m;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m = c[i] < 0 ? -c[i] : c[i];
        s += m * m;
      end
      for (int i = 0; i < 3; i++) begin
        m = c[i] < 0 ? -c[i] : c[i];
        if (s == 0) o[i] = 0;
        else begin
          m = root(((m * m) << 28) / s);
          o[i] = c[i] < 0 ? -longint'(m) : longint'(m);
        end
      end
    endfunction

    function longint unsigned pos_dot(longint a [3], longint b [3]);
      longint d;
      d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      return d > 0 ? longint'(d) >>> 14 : 0;
    endfunction

    function longint unsigned fmul(longint unsigned a, longint unsigned b);
      return (a * b) >> 14;
    endfunction

    function longint unsigned power200(longint unsigned x);
      longint unsigned p8, p64, p128;
      x = fmul(x, x);
      x = fmul(x, x);
      p8 = fmul(x, x);
      x = fmul(p8, p8);
      x = fmul(x, x);
      p64 = fmul(x, x);
      p128 = fmul(p64, p64);
      return fmul(fmul(p128, p64), p8);
    endfunction

    function void note_fragment(fragment_t f);
      longint vraw [3], v [3], lraw [3], l [3], rraw [3], r [3], nr [3];
      longint unsigned sum, ln, rv, sp, inten, c, q;
      int active;
      logic [7:0] ch [3];
      pixel_t px;
      sum = 0;
      for (int i = 0; i < 3; i++) nr[i] = f.nrm[i];
      vraw[0] = -longint'(f.pt[0]);
      vraw[1] = -longint'(f.pt[1]);
      vraw[2] = longint'(camera_z) - f.pt[2];
      unit_vec(vraw, v);
      active = light_count > NUM_LIGHTS ? NUM_LIGHTS : light_count;
      for (int k = 0; k < active; k++) begin
        inten = light_word[k][63:48];
        for (int i = 0; i < 3; i++)
          lraw[i] = longint'($signed(light_word[k][16*i +: 16])) - f.pt[i];
        unit_vec(lraw, l);
        ln = pos_dot(l, nr);
        for (int i = 0; i < 3; i++) begin
          longint qs;
          qs = l[i] * nr[i] * nr[i] * 2;
          q = (qs < 0 ? -qs : qs) >> 28;
          rraw[i] = (qs < 0 ? -longint'(q) : longint'(q)) - l[i];
        end
        unit_vec(rraw, r);
        rv = pos_dot(r, v);
        if (rv > pps_pkg::ONE_Q14) rv = pps_pkg::ONE_Q14;
        sp = power200(rv);
        sum += (ln * inten * pps_pkg::DIFF_K) >> 20;
        sum += (sp * inten * pps_pkg::SPEC_K) >> 22;
      end
      for (int i = 0; i < 3; i++) begin
        c = active == 0 ? 0 : (f.col[i] * sum) >> 16;
        ch[i] = c > 255 ? 8'd255 : c[7:0];
      end
      px = {ch[0], ch[1], ch[2]};
      pending = {pending, px};
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_px;
      if (pending.size() == 0) begin
        $error("unexpected pixel %h", got);
        errors++;
        return;
      end
      exp_px = pending.pop_front();
      if (got.red !== exp_px.red) begin
        $error("shaded_red exp %0d got %0d", exp_px.red, got.red); errors++;
      end
      if (got.green !== exp_px.green) begin
        $error("shaded_green exp %0d got %0d", exp_px.green, got.green); errors++;
      end
      if (got.blue !== exp_px.blue) begin
        $error("shaded_blue exp %0d got %0d", exp_px.blue, got.blue); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index = 0;
  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data = 0;
  pps_in_if  in_ch ();
  pps_out_if out_ch ();
  shade_scoreboard pix_sb;
  longint cycles = 0;
  bit hold_off = 0;
  bit stall_sink = 0;

  phong_pixel_shader_top #(.MAX_LIGHTS(NUM_LIGHTS)) i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // accepted transactions on both channels
  always @(posedge clk) begin
    fragment_t f;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      f.col[0] = in_ch.color_red; f.col[1] = in_ch.color_green; f.col[2] = in_ch.color_blue;
      f.pt[0] = in_ch.point_x; f.pt[1] = in_ch.point_y; f.pt[2] = in_ch.point_z;
      f.nrm[0] = in_ch.normal_x; f.nrm[1] = in_ch.normal_y; f.nrm[2] = in_ch.normal_z;
      pix_sb.note_fragment(f);
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      pix_sb.check_pixel({out_ch.shaded_red, out_ch.shaded_green, out_ch.shaded_blue});
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap, n;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 0;
        n = 0;
        while (n < 400) begin
          @(negedge clk);
          n++;
        end
        hold_off = 0;
      end
      gap = stall_sink ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  task automatic write_cfg(logic [pps_pkg::CFG_IDX_W-1:0] idx,
                           logic [pps_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    pix_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send(fragment_t f, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.color_red <= f.col[0]; in_ch.color_green <= f.col[1]; in_ch.color_blue <= f.col[2];
    in_ch.point_x <= f.pt[0]; in_ch.point_y <= f.pt[1]; in_ch.point_z <= f.pt[2];
    in_ch.normal_x <= f.nrm[0]; in_ch.normal_y <= f.nrm[1]; in_ch.normal_z <= f.nrm[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (pix_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_norm_comp();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // mostly a true unit normal, sometimes any in-range or raw 16-bit value
  function automatic fragment_t rand_fragment(bit wide);
    fragment_t f;
    int sel;
    real a, b, cx, cy, cz;
    for (int i = 0; i < 3; i++) f.col[i] = 8'($urandom);
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++)
      f.pt[i] = (wide || sel == 0) ? 16'($urandom)
                                   : 16'($signed(16'($urandom_range(0, 4000))) - 2000);
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      a = $urandom_range(0, 62831) / 10000.0;
      b = ($urandom_range(0, 20000) / 10000.0) - 1.0;
      cz = b; cx = $sqrt(1.0 - b * b) * $cos(a); cy = $sqrt(1.0 - b * b) * $sin(a);
      f.nrm[0] = 16'($rtoi(cx * 16384.0)); f.nrm[1] = 16'($rtoi(cy * 16384.0));
      f.nrm[2] = 16'($rtoi(cz * 16384.0));
    end else if (sel < 9) begin
      for (int i = 0; i < 3; i++) f.nrm[i] = rand_norm_comp();
    end else begin
      for (int i = 0; i < 3; i++) f.nrm[i] = 16'($urandom);
    end
    return f;
  endfunction

  function automatic logic [63:0] rand_light(bit wide);
    logic [63:0] w;
    for (int i = 0; i < 3; i++)
      w[16*i +: 16] = wide ? 16'($urandom) : 16'($signed(16'($urandom_range(0, 6000))) - 3000);
    w[63:48] = wide ? 16'($urandom) : 16'($urandom_range(0, 1024));
    return w;
  endfunction

  initial begin
    fragment_t f;
    int unsigned phase;
    in_ch.valid = 0;
    {in_ch.color_red, in_ch.color_green, in_ch.color_blue} = '0;
    {in_ch.point_x, in_ch.point_y, in_ch.point_z} = '0;
    {in_ch.normal_x, in_ch.normal_y, in_ch.normal_z} = '0;
    pix_sb = new();
    pix_sb.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // no lights: black
    f = rand_fragment(0);
    send(f, 0);
    drain();
    write_cfg(pps_pkg::CFG_LIGHT_COUNT, 64'd1);
    write_cfg(pps_pkg::CFG_LIGHT_0, {16'h0100, 16'sd0, 16'sd0, 16'sd0});
    drain();
    write_cfg(pps_pkg::CFG_LIGHT_0, {16'h0100, -16'sd1000, 16'sd0, 16'sd0});
    write_cfg(pps_pkg::CFG_CAMERA_Z, 64'h7);
    // directed: extremes of colors, points, normals, zero vectors
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 3; i++) begin
        f.col[i] = (k & 1) ? 8'hff : 8'h00;
        f.pt[i] = k[1] ? ((k & 4) ? 16'sh7fff : -16'sh8000) : 16'sd0;
        f.nrm[i] = 0;
      end
      f.nrm[k % 3] = (k & 8) ? -16'sd16384 : 16'sd16384;
      if (k == 14) f.pt = '{16'sd0, 16'sd0, 16'sd7};       // view vector zero
      if (k == 15) f.pt = '{16'sd0, 16'sd0, -16'sd1000};   // light vector zero
      if (k == 13) f.nrm = '{16'sh7fff, -16'sh8000, 16'sh7fff};
      send(f, 0);
    end
    drain();
    // light_count above the lane count, and the extreme counts
    write_cfg(pps_pkg::CFG_LIGHT_1, 64'hffff_7fff_8000_7fff);
    write_cfg(pps_pkg::CFG_LIGHT_2, 64'h0000_1234_5678_9abc);
    write_cfg(pps_pkg::CFG_LIGHT_3, 64'h0200_0100_0100_0100);
    write_cfg(pps_pkg::CFG_LIGHT_COUNT, 64'd7);
    write_cfg(pps_pkg::CFG_CAMERA_Z, 64'h8000);
    for (int k = 0; k < 6; k++) send(rand_fragment(k[0]), 0);
    drain();
    write_cfg(pps_pkg::CFG_LIGHT_COUNT, 64'd6);   // unused index test below
    write_cfg(3'd6, 64'hdead);
    write_cfg(3'd7, 64'hbeef);
    write_cfg(pps_pkg::CFG_CAMERA_Z, 64'h7fff);
    for (int k = 0; k < 3; k++) send(rand_fragment(1), 0);
    drain();

    stall_sink = 1;
    for (phase = 0; phase < 14; phase++) begin
      bit wide;
      wide = (phase % 4) == 3;
      write_cfg(pps_pkg::CFG_LIGHT_COUNT, phase == 0 ? 64'd0 : 64'($urandom_range(0, 7)));
      for (int i = 0; i < 4; i++)
        write_cfg(pps_pkg::CFG_IDX_W'(pps_pkg::CFG_LIGHT_0 + i), rand_light(wide));
      write_cfg(pps_pkg::CFG_CAMERA_Z, phase == 5 ? 64'h8000 :
                64'(16'($signed(16'($urandom_range(0, 8000))) - 4000)));
      if (phase == 2) hold_off = 1;
      for (int n = 0; n < 125; n++) begin
        // quiet stretches with no idling on either side
        int gap;
        gap = (phase % 3 == 1) ? 0 : $urandom_range(0, 19);
        if (phase == 2) gap = 0;
        stall_sink = phase % 3 != 1;
        send(rand_fragment(wide), gap);
      end
      drain();
    end

    if (pix_sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
